// ===== src/ipm_pkg.sv =====
package ipm_pkg;

  // Default table geometry.
  localparam int ENTRIES_DEF = 32;
  localparam int MAX_LEN_DEF = 16;

  // Fixed field widths of the stream words.
  localparam int KIND_W      = 2;
  localparam int IDX_FIELD_W = 5;
  localparam int POS_FIELD_W = 4;
  localparam int CHAR_W      = 8;
  localparam int LEN_FIELD_W = 5;
  localparam int S_TDATA_W   = 24;
  localparam int M_TDATA_W   = 8;

  // Accepted key codes: lowercase letters.
  localparam logic [CHAR_W-1:0] KEY_LO = 8'd97;
  localparam logic [CHAR_W-1:0] KEY_HI = 8'd122;

  // Word kinds as they arrive on tuser.
  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_KEY   = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  // Decoded operation carried down the cell chain.
  typedef enum logic [1:0] {
    OP_NOP   = 2'd0,
    OP_LOAD  = 2'd1,
    OP_KEY   = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  // Control that travels with a word from cell to cell.
  typedef struct packed {
    op_e  op;
    logic any;    // some entry seen so far is alive after this word
    logic found;  // some entry seen so far survived this key
  } ctl_t;

endpackage

// ===== src/incremental_prefix_matcher_top.sv =====
// Incremental prefix matcher. Table characters are loaded and keys typed as
// words on the slave stream; every accepted word yields exactly one result
// word on the master stream, in order. Each table entry lives in one cell of
// a chain of ENTRIES cells, and every word walks down the chain one cell per
// cycle, so a new word is taken every cycle while the output is not stalled,
// and its result is registered at the output after it leaves the last cell.
// A stall on the master side holds the whole chain. Key codes outside
// lowercase letters and unknown kinds leave the state alone but still
// produce a result word.
module incremental_prefix_matcher_top import ipm_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [4:0] entry_index, [8:5] char_position, [16:9] char_value,
  // [21:17] entry_length, [23:22] zero
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // [1:0] kind
  input  logic [KIND_W-1:0]    s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [0] best_valid, [5:1] best_index, [6] still_matching, [7] zero
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

  localparam int IW = $clog2(ENTRIES);
  localparam int LW = $clog2(MAX_LEN + 1);

  logic              adv;
  logic              accept;

  logic              valid_c [ENTRIES+1];
  ctl_t              ctl_c   [ENTRIES+1];
  logic [IW-1:0]     idx_c   [ENTRIES+1];
  logic [LW-1:0]     pos_c   [ENTRIES+1];
  logic [CHAR_W-1:0] chr_c   [ENTRIES+1];
  logic [LW-1:0]     len_c   [ENTRIES+1];
  logic [IW-1:0]     first_c [ENTRIES+1];

  logic                 out_valid_q;
  logic [M_TDATA_W-1:0] out_data_q;
  logic                 best_valid_q, best_valid_d;
  logic [IW-1:0]        best_index_q, best_index_d;
  ctl_t                 last_ctl;
  logic                 last_valid;

  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && adv;

  ipm_head #(
    .ENTRIES (ENTRIES),
    .MAX_LEN (MAX_LEN)
  ) u_head (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .kind_i   (s_axis_tuser),
    .idx_i    (s_axis_tdata[4:0]),
    .pos_i    (s_axis_tdata[8:5]),
    .chr_i    (s_axis_tdata[16:9]),
    .len_i    (s_axis_tdata[21:17]),
    .ctl_o    (ctl_c[0]),
    .idx_o    (idx_c[0]),
    .pos_o    (pos_c[0]),
    .chr_o    (chr_c[0]),
    .len_o    (len_c[0])
  );

  assign valid_c[0] = s_axis_tvalid;
  assign first_c[0] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    ipm_cell #(
      .ENTRIES (ENTRIES),
      .MAX_LEN (MAX_LEN),
      .IDX     (i)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .adv_i       (adv),
      .in_valid_i  (valid_c[i]),
      .in_ctl_i    (ctl_c[i]),
      .in_idx_i    (idx_c[i]),
      .in_pos_i    (pos_c[i]),
      .in_chr_i    (chr_c[i]),
      .in_len_i    (len_c[i]),
      .in_first_i  (first_c[i]),
      .out_valid_o (valid_c[i+1]),
      .out_ctl_o   (ctl_c[i+1]),
      .out_idx_o   (idx_c[i+1]),
      .out_pos_o   (pos_c[i+1]),
      .out_chr_o   (chr_c[i+1]),
      .out_len_o   (len_c[i+1]),
      .out_first_o (first_c[i+1])
    );
  end

  assign last_valid = valid_c[ENTRIES];
  assign last_ctl   = ctl_c[ENTRIES];

  // A key with no survivor keeps the previous best match.
  always_comb begin
    best_valid_d = best_valid_q;
    best_index_d = best_index_q;
    if (last_valid) begin
      unique case (last_ctl.op)
        OP_KEY: begin
          if (last_ctl.found) begin
            best_valid_d = 1'b1;
            best_index_d = first_c[ENTRIES];
          end
        end
        OP_CLEAR: begin
          best_valid_d = 1'b0;
          best_index_d = '0;
        end
        default: begin
          best_valid_d = best_valid_q;
          best_index_d = best_index_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      best_valid_q <= 1'b0;
      best_index_q <= '0;
    end else if (adv) begin
      out_valid_q  <= last_valid;
      best_valid_q <= best_valid_d;
      best_index_q <= best_index_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && last_valid) begin
      out_data_q <= {1'b0, last_ctl.any, 5'(best_index_d), best_valid_d};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_no_index_without_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_data_q[0] |-> out_data_q[5:1] == 5'd0)
    else $error("best index set while no best match is held");

  a_best_from_survivor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(best_valid_q) |-> $past(adv && last_valid && last_ctl.found))
    else $error("best match appeared without a surviving entry");

  a_found_implies_any: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_valid && last_ctl.found |-> last_ctl.any)
    else $error("survivor found but no entry reported alive");

endmodule

// ===== src/ipm_ram.sv =====
module ipm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/ipm_head.sv =====
module ipm_head import ipm_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [KIND_W-1:0]             kind_i,
  input  logic [IDX_FIELD_W-1:0]        idx_i,
  input  logic [POS_FIELD_W-1:0]        pos_i,
  input  logic [CHAR_W-1:0]             chr_i,
  input  logic [LEN_FIELD_W-1:0]        len_i,
  output ctl_t                          ctl_o,
  output logic [$clog2(ENTRIES)-1:0]    idx_o,
  output logic [$clog2(MAX_LEN+1)-1:0]  pos_o,
  output logic [CHAR_W-1:0]             chr_o,
  output logic [$clog2(MAX_LEN+1)-1:0]  len_o
);

  localparam int IW = $clog2(ENTRIES);
  localparam int LW = $clog2(MAX_LEN + 1);

  logic [LW-1:0] typed_q, typed_d;
  logic          load_ok;
  logic          key_ok;
  op_e           op;

  assign load_ok = (int'(idx_i) < ENTRIES) && (int'(pos_i) < MAX_LEN);
  assign key_ok  = (chr_i >= KEY_LO) && (chr_i <= KEY_HI);

  always_comb begin
    op      = OP_NOP;
    typed_d = typed_q;
    unique case (kind_e'(kind_i))
      KIND_LOAD: begin
        if (load_ok) op = OP_LOAD;
      end
      KIND_KEY: begin
        if (key_ok) begin
          op = OP_KEY;
          if (typed_q < LW'(MAX_LEN)) typed_d = typed_q + 1'b1;
        end
      end
      KIND_CLEAR: begin
        op      = OP_CLEAR;
        typed_d = '0;
      end
      default: op = OP_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      typed_q <= '0;
    end else if (accept_i) begin
      typed_q <= typed_d;
    end
  end

  // A key compares at the current typed length; a load writes its own position.
  assign ctl_o = '{op: op, any: 1'b0, found: 1'b0};
  assign idx_o = IW'(idx_i);
  assign pos_o = (op == OP_KEY) ? typed_q : LW'(pos_i);
  assign chr_o = chr_i;
  assign len_o = (int'(len_i) > MAX_LEN) ? LW'(MAX_LEN) : LW'(len_i);

  a_typed_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    typed_q <= LW'(MAX_LEN))
    else $error("typed length ran past the longest entry");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && op == OP_CLEAR |=> typed_q == '0)
    else $error("clear did not empty the typed text");

endmodule

// ===== src/ipm_cell.sv =====
module ipm_cell import ipm_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int MAX_LEN = MAX_LEN_DEF,
  parameter int IDX     = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          in_valid_i,
  input  ctl_t                          in_ctl_i,
  input  logic [$clog2(ENTRIES)-1:0]    in_idx_i,
  input  logic [$clog2(MAX_LEN+1)-1:0]  in_pos_i,
  input  logic [CHAR_W-1:0]             in_chr_i,
  input  logic [$clog2(MAX_LEN+1)-1:0]  in_len_i,
  input  logic [$clog2(ENTRIES)-1:0]    in_first_i,
  output logic                          out_valid_o,
  output ctl_t                          out_ctl_o,
  output logic [$clog2(ENTRIES)-1:0]    out_idx_o,
  output logic [$clog2(MAX_LEN+1)-1:0]  out_pos_o,
  output logic [CHAR_W-1:0]             out_chr_o,
  output logic [$clog2(MAX_LEN+1)-1:0]  out_len_o,
  output logic [$clog2(ENTRIES)-1:0]    out_first_o
);

  localparam int IW = $clog2(ENTRIES);
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int AW = $clog2(MAX_LEN);

  // Word held in this cell.
  logic              v_q;
  ctl_t              ctl_q;
  logic [IW-1:0]     idx_q;
  logic [LW-1:0]     pos_q;
  logic [CHAR_W-1:0] chr_q;
  logic [LW-1:0]     len_field_q;
  logic [IW-1:0]     first_q;

  // Entry state.
  logic              alive_q, alive_d;
  logic [LW-1:0]     len_q;
  logic              fwd_hit_q, fwd_hit_d;
  logic [CHAR_W-1:0] fwd_chr_q;

  logic              mine;
  logic              we;
  logic [CHAR_W-1:0] rdata;
  logic [CHAR_W-1:0] chr_eff;
  logic              keep;

  assign mine = v_q && (idx_q == IW'(IDX));
  assign we   = adv_i && mine && (ctl_q.op == OP_LOAD);

  // The next word reads its character as this one leaves; a load leaving at
  // the same edge to the same position is forwarded past the RAM.
  assign fwd_hit_d = we && (pos_q[AW-1:0] == in_pos_i[AW-1:0]);

  ipm_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (MAX_LEN)
  ) u_chars (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (pos_q[AW-1:0]),
    .wdata_i (chr_q),
    .re_i    (adv_i),
    .raddr_i (in_pos_i[AW-1:0]),
    .rdata_o (rdata)
  );

  assign chr_eff = fwd_hit_q ? fwd_chr_q : rdata;
  assign keep    = v_q && (ctl_q.op == OP_KEY) && alive_q &&
                   (pos_q < len_q) && (chr_eff == chr_q);

  always_comb begin
    alive_d = alive_q;
    if (v_q) begin
      unique case (ctl_q.op)
        OP_KEY:   alive_d = keep;
        OP_CLEAR: alive_d = 1'b1;
        default:  alive_d = alive_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q       <= 1'b0;
      alive_q   <= 1'b1;
      len_q     <= '0;
      fwd_hit_q <= 1'b0;
    end else if (adv_i) begin
      v_q       <= in_valid_i;
      alive_q   <= alive_d;
      fwd_hit_q <= fwd_hit_d;
      if (mine && ctl_q.op == OP_LOAD) begin
        len_q <= len_field_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ctl_q       <= in_ctl_i;
      idx_q       <= in_idx_i;
      pos_q       <= in_pos_i;
      chr_q       <= in_chr_i;
      len_field_q <= in_len_i;
      first_q     <= in_first_i;
      fwd_chr_q   <= chr_q;
    end
  end

  assign out_valid_o     = v_q;
  assign out_ctl_o.op    = ctl_q.op;
  assign out_ctl_o.any   = ctl_q.any | alive_d;
  assign out_ctl_o.found = ctl_q.found | keep;
  assign out_idx_o       = idx_q;
  assign out_pos_o       = pos_q;
  assign out_chr_o       = chr_q;
  assign out_len_o       = len_field_q;
  assign out_first_o     = (keep && !ctl_q.found) ? IW'(IDX) : first_q;

  a_revive_by_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(alive_q) |-> $past(adv_i && v_q && ctl_q.op == OP_CLEAR))
    else $error("entry revived without a clear");

  a_len_by_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(len_q) |-> $past(adv_i && mine && ctl_q.op == OP_LOAD))
    else $error("entry length changed without a load");

  a_len_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LW'(MAX_LEN))
    else $error("entry length above the longest entry");

endmodule

// ===== bench/tb.sv =====
module tb;
  import ipm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES = ENTRIES_DEF;
  localparam int MAX_LEN = MAX_LEN_DEF;
  localparam int LATENCY = ENTRIES + 1;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic       spare;
    logic       still_matching;
    logic [4:0] best_index;
    logic       best_valid;
  } match_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [KIND_W-1:0]    s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  // Shadow of the matcher state.
  logic [CHAR_W-1:0]      tbl_chars [ENTRIES][MAX_LEN];
  logic [LEN_FIELD_W-1:0] tbl_len [ENTRIES];
  logic [ENTRIES-1:0]     alive;
  int                     typed_len;
  logic [4:0]             best_idx;
  logic                   best_ok;

  match_t pending_matches[$];
  int     applied_words = 0;
  int     errors = 0;
  bit     steady = 1'b0;
  int     sink_left = 0;

  incremental_prefix_matcher_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Mostly a tiny alphabet so that entries share long prefixes.
  function automatic logic [CHAR_W-1:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return CHAR_W'($urandom_range(97, 99));
    if (r < 90) return CHAR_W'($urandom_range(KEY_LO, KEY_HI));
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [LEN_FIELD_W-1:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return LEN_FIELD_W'(MAX_LEN);
    if (r < 30) return LEN_FIELD_W'($urandom_range(MAX_LEN + 1, 31));
    return LEN_FIELD_W'($urandom_range(1, 8));
  endfunction

  // Updates the shadow state for one accepted word and queues its result.
  task automatic apply_word(logic [KIND_W-1:0] k, logic [4:0] idx, logic [3:0] pos,
                            logic [CHAR_W-1:0] val, logic [LEN_FIELD_W-1:0] len);
    match_t res;
    logic   found;
    logic   keep;
    logic [4:0] first_hit;
    found = 1'b0;
    first_hit = '0;
    case (k)
      KIND_LOAD: begin
        tbl_chars[idx][pos] = val;
        tbl_len[idx] = (len > MAX_LEN) ? LEN_FIELD_W'(MAX_LEN) : len;
        applied_words++;
      end
      KIND_KEY: begin
        if (val >= KEY_LO && val <= KEY_HI) begin
          for (int i = 0; i < ENTRIES; i++) begin
            keep = 1'b0;
            if (alive[i] && typed_len < MAX_LEN && typed_len < tbl_len[i]) begin
              keep = (tbl_chars[i][typed_len] == val);
            end
            alive[i] = keep;
            if (keep && !found) begin
              found = 1'b1;
              first_hit = 5'(i);
            end
          end
          if (found) begin
            best_idx = first_hit;
            best_ok = 1'b1;
          end
          if (typed_len < MAX_LEN) typed_len++;
          applied_words++;
        end
      end
      KIND_CLEAR: begin
        typed_len = 0;
        alive = '1;
        best_idx = '0;
        best_ok = 1'b0;
        applied_words++;
      end
      default: ;
    endcase
    res.spare = 1'b0;
    res.best_valid = best_ok;
    res.best_index = best_idx;
    res.still_matching = |alive;
    pending_matches.insert(pending_matches.size(), res);
  endtask

  task automatic send_word(logic [KIND_W-1:0] k, logic [4:0] idx, logic [3:0] pos,
                           logic [CHAR_W-1:0] val, logic [LEN_FIELD_W-1:0] len);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= k;
    s_axis_tdata  <= {2'b00, len, val, pos, idx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    apply_word(k, idx, pos, val, len);
  endtask

  // Other fields carry random junk so that the block is seen to ignore them.
  task automatic send_key(logic [CHAR_W-1:0] val);
    send_word(KIND_KEY, 5'($urandom), 4'($urandom), val, 5'($urandom));
  endtask

  task automatic send_clear();
    send_word(KIND_CLEAR, 5'($urandom), 4'($urandom), 8'($urandom), 5'($urandom));
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk_i);
  endtask

  // All lengths are zero after reset, so a key reads no table character.
  task automatic test_empty_table();
    send_key(8'd97);
    send_clear();
    wait_drain();
  endtask

  // Every character of every entry gets written before any key can read it.
  // The last entry is all 'z' with an overlong length for the typing test.
  task automatic load_full_table();
    logic [LEN_FIELD_W-1:0] len;
    logic [CHAR_W-1:0]      ch;
    for (int i = 0; i < ENTRIES; i++) begin
      len = (i == ENTRIES - 1) ? 5'd31 : pick_len();
      for (int p = 0; p < MAX_LEN; p++) begin
        ch = (i == ENTRIES - 1) ? KEY_HI : pick_char();
        send_word(KIND_LOAD, 5'(i), 4'(p), ch, len);
      end
    end
  endtask

  task automatic test_key_bounds();
    send_clear();
    send_key(KEY_LO - 8'd1);
    send_key(KEY_HI + 8'd1);
    send_key(KEY_LO);
    // A load in the middle of typing must not touch the alive flags.
    send_word(KIND_LOAD, 5'd0, 4'd1, KEY_HI, 5'd5);
    send_key(KEY_HI);
    send_word(KIND_UNUSED, 5'd31, 4'd15, 8'd97, 5'd31);
    send_key(8'd255);
    send_key(8'd0);
    wait_drain();
  endtask

  // Typing past the longest possible entry must keep the last best match.
  task automatic test_typing_overflow();
    send_clear();
    for (int j = 0; j <= MAX_LEN; j++) send_key(KEY_HI);
  endtask

  task automatic test_random_sessions(int words);
    int goal;
    int r;
    int t;
    int keys;
    goal = applied_words + words;
    while (applied_words < goal) begin
      steady = (goal - applied_words) > words - 120;
      r = $urandom_range(0, 99);
      if (r < 65) begin
        // Clear, then type along one entry with occasional wrong letters and loads.
        send_clear();
        t = $urandom_range(0, ENTRIES - 1);
        keys = $urandom_range(1, tbl_len[t] + 2);
        for (int j = 0; j < keys; j++) begin
          r = $urandom_range(0, 99);
          if (r < 4) begin
            send_word(KIND_LOAD, 5'($urandom), 4'($urandom), pick_char(), pick_len());
          end else if (r < 8) begin
            send_key(8'($urandom_range(0, 255)));
          end
          if (j < tbl_len[t] && $urandom_range(0, 9) != 0) begin
            send_key(tbl_chars[t][j]);
          end else begin
            send_key(CHAR_W'($urandom_range(KEY_LO, KEY_HI)));
          end
        end
      end else if (r < 85) begin
        send_word(KIND_LOAD, 5'($urandom), 4'($urandom), pick_char(), pick_len());
      end else if (r < 95) begin
        send_key(8'($urandom_range(0, 255)));
      end else if (r < 98) begin
        send_word(KIND_UNUSED, 5'($urandom), 4'($urandom), 8'($urandom), 5'($urandom));
      end else begin
        send_clear();
      end
    end
    steady = 1'b0;
  endtask

  // Result checking and random backpressure on the master side.
  always @(posedge clk_i) begin
    match_t got;
    match_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = match_t'(m_axis_tdata);
      if (pending_matches.size() == 0) begin
        if (errors < 10) $display("unexpected result word %h", m_axis_tdata);
        errors++;
      end else begin
        want = pending_matches.pop_front();
        if (got.best_valid !== want.best_valid || got.best_index !== want.best_index ||
            got.still_matching !== want.still_matching) begin
          if (errors < 10) begin
            $display("mismatch: expected valid=%b index=%0d matching=%b,",
                     want.best_valid, want.best_index, want.still_matching,
                     " got valid=%b index=%0d matching=%b",
                     got.best_valid, got.best_index, got.still_matching);
          end
          errors++;
        end
      end
    end
    if (steady) begin
      m_axis_tready <= 1'b1;
      sink_left = 0;
    end else if (sink_left > 0) begin
      sink_left--;
    end else if (m_axis_tready) begin
      sink_left = pick_gap();
      if (sink_left > 0) m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      sink_left = $urandom_range(0, 30);
    end
  end

  initial begin
    for (int i = 0; i < ENTRIES; i++) tbl_len[i] = '0;
    alive = '1;
    typed_len = 0;
    best_idx = '0;
    best_ok = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    load_full_table();
    test_key_bounds();
    test_typing_overflow();
    wait_drain();
    test_random_sessions(200);
    wait_drain();
    repeat (2 * LATENCY) @(posedge clk_i);
    errors += pending_matches.size();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
